[design/longest_idle_slot_allocator_assert.svh]
// assertion macros for the longest idle slot allocator checker
`ifndef LONGEST_IDLE_SLOT_ALLOCATOR_ASSERT_SVH
`define LONGEST_IDLE_SLOT_ALLOCATOR_ASSERT_SVH

// clocked assertion, off during reset
`define LISA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// next-cycle implication built on the macro above
`define LISA_ASSERT_NEXT(lbl, pre, post, msg) \
  `LISA_ASSERT(lbl, (pre) |=> (post), msg)

`endif

[design/lisa_pkg.sv]
// shared types and constants of the longest idle slot allocator
package lisa_pkg;

  localparam int DEF_ENTRIES   = 64;
  localparam int DEF_TIME_BITS = 32;

  localparam int KEY_HI_W   = 16;
  localparam int KEY_LO_W   = 64;
  localparam int KEY_W      = KEY_HI_W + KEY_LO_W;
  localparam int CFG_W      = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int POS_W      = 6;
  localparam int REM_W      = 7;
  localparam int STATUS_W   = 2;
  localparam int IN_DATA_W  = KEY_W;
  localparam int OUT_DATA_W = 24;

  localparam logic [CFG_W-1:0] CFG_ENTRIES_RST = 7'd64;
  localparam logic [CFG_W-1:0] CFG_SLOTS_RST   = 7'd8;

  localparam logic [CFG_IDX_W-1:0] CFG_ENTRIES_IN_USE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOTS_PER_FLOOR = 2'd1;

  localparam logic [STATUS_W-1:0] STS_PLACED    = 2'd0;
  localparam logic [STATUS_W-1:0] STS_FULL      = 2'd1;
  localparam logic [STATUS_W-1:0] STS_RELEASED  = 2'd2;
  localparam logic [STATUS_W-1:0] STS_NOT_FOUND = 2'd3;

  localparam logic FUNC_ALLOC   = 1'b0;
  localparam logic FUNC_RELEASE = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_COMMIT,
    ST_DIV,
    ST_OUT
  } lisa_state_e;

  typedef struct packed {
    logic start;
    logic rel;
    logic commit;
    logic commit_rel;
  } lisa_scan_req_t;

  typedef struct packed {
    logic ready;
    logic done;
    logic hit;
  } lisa_scan_rsp_t;

endpackage

[design/longest_idle_slot_allocator.sv]
// Longest idle slot allocator: one request at a time walks the entry table through a
// single memory read port, one entry per cycle, aging free entries and picking the
// longest idle free entry (allocate) or the first occupied entry holding the key
// (release); a bit-serial divider then splits the index into floor and slot. The scan
// covers the entries in use (entries_in_use, at most ENTRIES). A placed or released
// result passes through the scan, a commit, the divider and the output state in that
// order; full and not-found results skip the commit and the divider. The input
// takes the next request from the cycle the result shows. After reset a clearing
// pass over all ENTRIES entries zeroes the idle counters and occupied flags, and no
// request is taken until it ends. A finished result waits in the output register
// while the next request is accepted.
module longest_idle_slot_allocator #(
  parameter int ENTRIES   = lisa_pkg::DEF_ENTRIES,
  parameter int TIME_BITS = lisa_pkg::DEF_TIME_BITS
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // key_high[15:0], key_low[79:16]
  input  logic [lisa_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // func
  input  logic                            s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // floor_index[5:0], slot_index[11:6], remaining[18:12], zero[23:19]
  output logic [lisa_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // status
  output logic [lisa_pkg::STATUS_W-1:0]   m_axis_tuser,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [lisa_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [lisa_pkg::CFG_W-1:0]      cfg_data_i
);
  import lisa_pkg::*;

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W = $clog2(ENTRIES + 1);

  lisa_state_e         state_q, state_d;
  logic [CFG_W-1:0]    cfg_eiu_q, cfg_spf_q;
  logic [CNT_W-1:0]    cnt_q, act, rem_calc;
  logic                func_q, has_idx_q;
  logic [KEY_W-1:0]    key_q;
  logic [STATUS_W-1:0] status_q;
  logic                out_valid_q;
  logic [STATUS_W-1:0] out_status_q;
  logic [POS_W-1:0]    out_floor_q, out_slot_q;
  logic [REM_W-1:0]    out_rem_q;

  lisa_scan_req_t      scan_req;
  lisa_scan_rsp_t      scan_rsp;
  logic [IDX_W-1:0]    scan_idx;
  logic                in_fire, out_free, alloc_ok, div_start, div_done;
  logic [CFG_W-1:0]    spf;
  logic [IDX_W-1:0]    quot;
  logic [CFG_W-1:0]    rem;

  always_comb begin
    if (int'(cfg_eiu_q) > ENTRIES) begin
      act = CNT_W'(ENTRIES);
    end else begin
      act = CNT_W'(cfg_eiu_q);
    end
    rem_calc = (act > cnt_q) ? act - cnt_q : '0;
    spf      = (cfg_spf_q == '0) ? CFG_W'(1) : cfg_spf_q;
    alloc_ok = (cnt_q < act) && scan_rsp.hit;
    out_free = !out_valid_q || m_axis_tready;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (scan_rsp.ready) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_fire) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (scan_rsp.done) begin
          if (func_q == FUNC_ALLOC) begin
            state_d = alloc_ok ? ST_COMMIT : ST_OUT;
          end else begin
            state_d = scan_rsp.hit ? ST_COMMIT : ST_OUT;
          end
        end
      end
      ST_COMMIT: state_d = ST_DIV;
      ST_DIV: begin
        if (div_done) state_d = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  always_comb begin
    s_axis_tready       = (state_q == ST_IDLE);
    in_fire             = s_axis_tvalid && s_axis_tready;
    scan_req.start      = in_fire;
    scan_req.rel        = s_axis_tuser;
    scan_req.commit     = (state_q == ST_COMMIT);
    scan_req.commit_rel = func_q;
    div_start           = (state_q == ST_COMMIT);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      cfg_eiu_q   <= CFG_ENTRIES_RST;
      cfg_spf_q   <= CFG_SLOTS_RST;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_ENTRIES_IN_USE:  cfg_eiu_q <= cfg_data_i;
          CFG_SLOTS_PER_FLOOR: cfg_spf_q <= cfg_data_i;
          default: ;
        endcase
      end
      if ((state_q == ST_SCAN) && scan_rsp.done) begin
        if (func_q == FUNC_ALLOC) begin
          if (alloc_ok) cnt_q <= cnt_q + CNT_W'(1);
        end else if (scan_rsp.hit && (cnt_q != '0)) begin
          cnt_q <= cnt_q - CNT_W'(1);
        end
      end
      if ((state_q == ST_OUT) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      func_q <= s_axis_tuser;
      key_q  <= s_axis_tdata;
    end
    if ((state_q == ST_SCAN) && scan_rsp.done) begin
      if (func_q == FUNC_ALLOC) begin
        status_q  <= alloc_ok ? STS_PLACED : STS_FULL;
        has_idx_q <= alloc_ok;
      end else begin
        status_q  <= scan_rsp.hit ? STS_RELEASED : STS_NOT_FOUND;
        has_idx_q <= scan_rsp.hit;
      end
    end
    if ((state_q == ST_OUT) && out_free) begin
      out_status_q <= status_q;
      out_floor_q  <= has_idx_q ? POS_W'(quot) : '0;
      out_slot_q   <= has_idx_q ? rem[POS_W-1:0] : '0;
      out_rem_q    <= REM_W'(rem_calc);
    end
  end

  lisa_table #(
    .ENTRIES   (ENTRIES),
    .TIME_BITS (TIME_BITS),
    .IDX_W     (IDX_W),
    .CNT_W     (CNT_W)
  ) u_table (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (scan_req),
    .act_i  (act),
    .key_i  (key_q),
    .rsp_o  (scan_rsp),
    .idx_o  (scan_idx)
  );

  lisa_div #(
    .IDX_W (IDX_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (scan_idx),
    .divisor_i  (spf),
    .done_o     (div_done),
    .quot_o     (quot),
    .rem_o      (rem)
  );

  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tdata  = {5'b0, out_rem_q, out_slot_q, out_floor_q};

endmodule

[design/lisa_table.sv]
// entry table memories with the sequential scan and compare unit
module lisa_table #(
  parameter int ENTRIES   = lisa_pkg::DEF_ENTRIES,
  parameter int TIME_BITS = lisa_pkg::DEF_TIME_BITS,
  parameter int IDX_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
  parameter int CNT_W     = $clog2(ENTRIES + 1)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  lisa_pkg::lisa_scan_req_t    req_i,
  input  logic [CNT_W-1:0]            act_i,
  input  logic [lisa_pkg::KEY_W-1:0]  key_i,
  output lisa_pkg::lisa_scan_rsp_t    rsp_o,
  output logic [IDX_W-1:0]            idx_o
);
  import lisa_pkg::*;

  localparam int ST_W = TIME_BITS + 1;

  logic [ST_W-1:0]      st_mem [ENTRIES];
  logic [KEY_W-1:0]     key_mem [ENTRIES];

  logic                 clr_q;
  logic [IDX_W-1:0]     clr_addr_q;
  logic                 run_q, pv_q, rel_q, have_q;
  logic [CNT_W-1:0]     issue_q;
  logic [IDX_W-1:0]     paddr_q, best_q;
  logic [TIME_BITS-1:0] best_idle_q;
  logic [ST_W-1:0]      st_rdata_q;
  logic [KEY_W-1:0]     key_rdata_q;

  logic                 issue_go, done, occ, hit_now, better;
  logic [IDX_W-1:0]     raddr, waddr;
  logic [TIME_BITS-1:0] idle, idle_new;
  logic                 st_we, key_we;
  logic [ST_W-1:0]      st_wdata;

  always_comb begin
    issue_go = run_q && (issue_q < act_i);
    raddr    = issue_q[IDX_W-1:0];
    done     = run_q && !issue_go && !pv_q;
    occ      = st_rdata_q[TIME_BITS];
    idle     = st_rdata_q[TIME_BITS-1:0];
    idle_new = (!occ && (idle != '1)) ? idle + TIME_BITS'(1) : idle;
    hit_now  = pv_q && (rel_q ? (occ && (key_rdata_q == key_i)) : !occ);
    better   = rel_q ? !have_q : (!have_q || (idle_new > best_idle_q));
  end

  always_comb begin
    st_we    = 1'b0;
    key_we   = 1'b0;
    waddr    = paddr_q;
    st_wdata = {occ, idle_new};
    if (clr_q) begin
      st_we    = 1'b1;
      waddr    = clr_addr_q;
      st_wdata = '0;
    end else if (pv_q) begin
      st_we    = 1'b1;
    end else if (req_i.commit) begin
      st_we    = 1'b1;
      key_we   = !req_i.commit_rel;
      waddr    = best_q;
      st_wdata = {!req_i.commit_rel, {TIME_BITS{1'b0}}};
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_we) begin
      st_mem[waddr] <= st_wdata;
    end
    if (key_we) begin
      key_mem[waddr] <= key_i;
    end
    st_rdata_q  <= st_mem[raddr];
    key_rdata_q <= key_mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= 1'b1;
      clr_addr_q <= '0;
      run_q      <= 1'b0;
      pv_q       <= 1'b0;
      rel_q      <= 1'b0;
      have_q     <= 1'b0;
      issue_q    <= '0;
    end else begin
      if (clr_q) begin
        clr_addr_q <= clr_addr_q + IDX_W'(1);
        if (clr_addr_q == IDX_W'(ENTRIES - 1)) begin
          clr_q <= 1'b0;
        end
      end
      if (req_i.start) begin
        run_q   <= 1'b1;
        pv_q    <= 1'b0;
        rel_q   <= req_i.rel;
        have_q  <= 1'b0;
        issue_q <= '0;
      end else if (run_q) begin
        pv_q <= issue_go;
        if (issue_go) begin
          issue_q <= issue_q + CNT_W'(1);
        end
        if (hit_now && better) begin
          have_q <= 1'b1;
        end
        if (done) begin
          run_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    paddr_q <= raddr;
    if (run_q && hit_now && better) begin
      best_q      <= paddr_q;
      best_idle_q <= idle_new;
    end
  end

  assign rsp_o.ready = !clr_q;
  assign rsp_o.done  = done;
  assign rsp_o.hit   = have_q;
  assign idx_o       = best_q;

endmodule

[design/lisa_div.sv]
// bit-serial restoring divider splitting an entry index into floor and slot
module lisa_div #(
  parameter int IDX_W = 6
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [IDX_W-1:0]           dividend_i,
  input  logic [lisa_pkg::CFG_W-1:0] divisor_i,
  output logic                       done_o,
  output logic [IDX_W-1:0]           quot_o,
  output logic [lisa_pkg::CFG_W-1:0] rem_o
);
  import lisa_pkg::*;

  localparam int STEP_W = $clog2(IDX_W + 1);

  logic              busy_q;
  logic [STEP_W-1:0] cnt_q;
  logic [IDX_W-1:0]  q_q;
  logic [CFG_W-1:0]  r_q, div_q;
  logic [CFG_W:0]    trial, diff;
  logic              ge;

  always_comb begin
    trial = {r_q, q_q[IDX_W-1]};
    ge    = trial >= {1'b0, div_q};
    diff  = trial - {1'b0, div_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= STEP_W'(IDX_W);
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
      end else begin
        cnt_q <= cnt_q - STEP_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      q_q   <= dividend_i;
      r_q   <= '0;
      div_q <= divisor_i;
    end else if (busy_q && (cnt_q != '0)) begin
      q_q <= (q_q << 1) | IDX_W'(ge);
      r_q <= ge ? diff[CFG_W-1:0] : trial[CFG_W-1:0];
    end
  end

  assign done_o = busy_q && (cnt_q == '0);
  assign quot_o = q_q;
  assign rem_o  = r_q;

endmodule

[design/lisa_checker.sv]
// port-level assertion checker for the longest idle slot allocator, bound to the top
`include "longest_idle_slot_allocator_assert.svh"

module lisa_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [lisa_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input logic [lisa_pkg::STATUS_W-1:0]   m_axis_tuser
);
  import lisa_pkg::*;

  `LISA_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")
  `LISA_ASSERT(a_no_pos, m_axis_tvalid && (m_axis_tuser == STS_FULL || m_axis_tuser == STS_NOT_FOUND) |-> m_axis_tdata[11:0] == 12'd0, "floor or slot set without an entry")
  `LISA_ASSERT_NEXT(a_one_req, s_axis_tvalid && s_axis_tready, !s_axis_tready, "second request taken while busy")
  `LISA_ASSERT(a_result_frees, $rose(m_axis_tvalid) |-> s_axis_tready, "result shown while still busy")

endmodule

bind longest_idle_slot_allocator lisa_checker u_lisa_checker (.*);
